// ===== design/i2cacc_pkg.sv =====
package i2cacc_pkg;

  localparam int REG_COUNT = 64;
  localparam int REG_AW = $clog2(REG_COUNT);

  typedef enum logic [1:0] {
    FUNC_START = 2'd0,
    FUNC_EVENT = 2'd1,
    FUNC_WRITE = 2'd2,
    FUNC_READ  = 2'd3
  } func_t;

  typedef struct packed {
    func_t       func;
    logic [7:0]  data;
    logic [62:0] now_ns;
  } in_req_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       irq_level;
  } out_req_t;

  localparam logic [7:0] CHIP_ID_RESET = 8'hf8;

  localparam logic [REG_AW-1:0] ADDR_DATA_LO = 6'h02;
  localparam logic [REG_AW-1:0] ADDR_DATA_HI = 6'h07;
  localparam logic [REG_AW-1:0] ADDR_RANGE   = 6'h0f;
  localparam logic [REG_AW-1:0] ADDR_BW      = 6'h10;
  localparam logic [REG_AW-1:0] ADDR_PWR     = 6'h11;
  localparam logic [REG_AW-1:0] ADDR_SOFTRST = 6'h14;
  localparam logic [REG_AW-1:0] ADDR_INTOUT  = 6'h20;
  localparam logic [REG_AW-1:0] ADDR_LATCH   = 6'h21;
  localparam logic [REG_AW-1:0] ADDR_KEEP0   = 6'h3b;
  localparam logic [REG_AW-1:0] ADDR_KEEP1   = 6'h3c;
  localparam logic [REG_AW-1:0] ADDR_LAST    = 6'h3f;

  localparam logic [7:0] SOFTRST_KEY  = 8'hb6;
  localparam logic [7:0] LATCH_MASK   = 8'h0f;
  localparam logic [7:0] SUSPEND_MASK = 8'ha0;

  localparam logic [3:0] RANGE_4G  = 4'h5;
  localparam logic [3:0] RANGE_8G  = 4'h8;
  localparam logic [3:0] RANGE_16G = 4'hc;

  localparam logic [25:0] SAMPLE_BASE_NS = 26'd64000000;
  localparam logic [4:0]  BW_MIN = 5'd8;
  localparam logic [4:0]  BW_MAX = 5'd15;

  localparam logic [7:0] REG_DEFAULTS [REG_COUNT] = '{
    8'hf8, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h80, 8'h00, 8'h00, 8'h03,
    8'h0f, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h05, 8'h00, 8'h09, 8'h30, 8'h81, 8'h0f, 8'hc0, 8'h00,
    8'h14, 8'h14, 8'h04, 8'h0a, 8'h18, 8'h48, 8'h08, 8'h11,
    8'h00, 8'hff, 8'h00, 8'hf4, 8'h00, 8'h00, 8'h10, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'hff, 8'h00, 8'h00
  };

endpackage

// ===== design/i2cacc_ram.sv =====
module i2cacc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/i2c_accel_register_model.sv =====
// Register side of a motionless accelerometer on an I2C bus.
// Input channel (in_valid / in_stall / in_req): one bus event per request,
// a start of write, another bus event, a written byte or a read, together
// with the current time in nanoseconds.
// Result channel (out_valid / out_stall / out_req): exactly one result per
// request, in order: the byte read (zero for anything but a read) and the
// interrupt line level after the request.
// Configuration port (cfg_we / cfg_wdata): the chip identifier that is
// loaded into register 0 at the next soft reset; a block reset restores
// the default identifier. Requests pass the middle stage, then the result
// register; one request is taken every cycle while in_stall is low.
// Model state changes at the acceptance edge; the register file
// read goes through one registered RAM port, then the result register.
// A stalled receiver holds the result register; a second request waits in
// the middle stage, and in_stall rises only when both are full.
// Reset (rst_n low, synchronous) loads the default register values, sets
// the pointer to 0, expects a pointer byte, sets all new-data bits and
// clears the sample time. Defaults come from per-entry valid bits, so no
// clearing pass is needed and requests are taken right after reset.
module i2c_accel_register_model
  import i2cacc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_req_t  in_req,
  output logic     out_valid,
  input  logic     out_stall,
  output out_req_t out_req,
  input  logic     cfg_we,
  input  logic [7:0] cfg_wdata
);

  logic [7:0]          chip_id_r;
  logic [7:0]          reg0_r,  reg0_nxt;
  logic [REG_AW-1:0]   ptr_r,   ptr_nxt;
  logic                pflag_r, pflag_nxt;
  logic [2:0]          nd_r,    nd_nxt;
  logic [62:0]         last_r,  last_nxt;
  logic [REG_COUNT-1:0] vld_r,  vld_nxt;
  logic [7:0]          range_r, range_nxt;
  logic [7:0]          bw_r,    bw_nxt;
  logic [7:0]          pwr_r,   pwr_nxt;
  logic [7:0]          intout_r, intout_nxt;

  logic       s1_valid_r, s1_valid_nxt;
  logic       s1_ram_r;
  logic [7:0] s1_byte_r;
  logic       s1_irq_r;
  logic       out_valid_r, out_valid_nxt;
  out_req_t   out_req_r;

  logic              accept, s2_load;
  logic              wr_byte, ptr_byte, data_wr, rd;
  logic [REG_AW-1:0] addr, addr_inc;
  logic              storable, ram_we, soft_rst;
  logic [7:0]        ram_wdata, ram_rdata;
  logic [2:0]        bw_idx;
  logic [25:0]       interval;
  logic [63:0]       diff;
  logic              resample;
  logic [2:0]        nd_pre;
  logic              is_data;
  logic [1:0]        axis;
  logic [7:0]        zscale;
  logic              s1_ram_nxt;
  logic [7:0]        s1_byte_nxt;
  logic [REG_COUNT-1:0] keep_mask;

  assign s2_load  = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !s2_load;
  assign accept   = in_valid && !in_stall;

  assign wr_byte  = accept && (in_req.func == FUNC_WRITE);
  assign ptr_byte = wr_byte && pflag_r;
  assign data_wr  = wr_byte && !pflag_r;
  assign rd       = accept && (in_req.func == FUNC_READ);
  assign addr     = ptr_r;
  assign addr_inc = addr + REG_AW'(1);

  assign storable = (addr >= ADDR_RANGE) && (addr != ADDR_LAST) && (addr != ADDR_SOFTRST);
  assign ram_we   = data_wr && storable;
  assign ram_wdata = (addr == ADDR_LATCH) ? (in_req.data & LATCH_MASK) : in_req.data;
  assign soft_rst = data_wr && (addr == ADDR_SOFTRST) && (in_req.data == SOFTRST_KEY);

  always_comb begin
    keep_mask = '0;
    keep_mask[ADDR_KEEP0] = 1'b1;
    keep_mask[ADDR_KEEP1] = 1'b1;
  end

  // bandwidth-timed resample
  always_comb begin
    if (bw_r[4:0] < BW_MIN) begin
      bw_idx = 3'd0;
    end else if (bw_r[4:0] > BW_MAX) begin
      bw_idx = 3'd7;
    end else begin
      bw_idx = bw_r[2:0];
    end
  end

  assign interval = SAMPLE_BASE_NS >> bw_idx;
  assign diff     = {1'b0, in_req.now_ns} - {1'b0, last_r};
  assign resample = rd && ((pwr_r & SUSPEND_MASK) == 8'h00) && !diff[63]
                    && (diff[62:0] >= {37'b0, interval});
  assign nd_pre   = resample ? 3'b111 : nd_r;

  assign is_data = (addr >= ADDR_DATA_LO) && (addr <= ADDR_DATA_HI);
  assign axis    = addr[2:1] - 2'd1;

  always_comb begin
    case (range_r[3:0])
      RANGE_4G:  zscale = 8'd32;
      RANGE_8G:  zscale = 8'd16;
      RANGE_16G: zscale = 8'd8;
      default:   zscale = 8'd64;
    endcase
  end

  always_comb begin
    ptr_nxt    = ptr_r;
    pflag_nxt  = pflag_r;
    nd_nxt     = nd_pre;
    last_nxt   = resample ? in_req.now_ns : last_r;
    vld_nxt    = vld_r;
    reg0_nxt   = reg0_r;
    range_nxt  = range_r;
    bw_nxt     = bw_r;
    pwr_nxt    = pwr_r;
    intout_nxt = intout_r;
    s1_ram_nxt  = 1'b0;
    s1_byte_nxt = 8'h00;

    if (accept && (in_req.func == FUNC_START)) begin
      pflag_nxt = 1'b1;
    end
    if (ptr_byte) begin
      ptr_nxt   = in_req.data[REG_AW-1:0];
      pflag_nxt = 1'b0;
    end
    if (data_wr) begin
      ptr_nxt = addr_inc;
    end
    if (rd && (addr != ADDR_LAST)) begin
      ptr_nxt = addr_inc;
    end

    if (ram_we) begin
      vld_nxt[addr] = 1'b1;
      if (addr == ADDR_RANGE)  range_nxt  = ram_wdata;
      if (addr == ADDR_BW)     bw_nxt     = ram_wdata;
      if (addr == ADDR_PWR)    pwr_nxt    = ram_wdata;
      if (addr == ADDR_INTOUT) intout_nxt = ram_wdata;
    end

    if (soft_rst) begin
      vld_nxt    = vld_r & keep_mask;
      reg0_nxt   = chip_id_r;
      range_nxt  = REG_DEFAULTS[ADDR_RANGE];
      bw_nxt     = REG_DEFAULTS[ADDR_BW];
      pwr_nxt    = REG_DEFAULTS[ADDR_PWR];
      intout_nxt = REG_DEFAULTS[ADDR_INTOUT];
      nd_nxt     = 3'b111;
      last_nxt   = in_req.now_ns;
    end

    if (rd) begin
      if (is_data) begin
        if (!addr[0]) begin
          s1_byte_nxt = {7'b0, nd_pre[axis]};
        end else begin
          nd_nxt = nd_pre & ~(3'b001 << axis);
          s1_byte_nxt = (axis == 2'd2) ? zscale : 8'h00;
        end
      end else if (vld_r[addr]) begin
        s1_ram_nxt = 1'b1;
      end else if (addr == '0) begin
        s1_byte_nxt = reg0_r;
      end else begin
        s1_byte_nxt = REG_DEFAULTS[addr];
      end
    end
  end

  assign s1_valid_nxt  = accept ? 1'b1 : (s2_load ? 1'b0 : s1_valid_r);
  assign out_valid_nxt = s2_load ? 1'b1 : (out_stall ? out_valid_r : 1'b0);

  i2cacc_ram #(
    .WIDTH (8),
    .DEPTH (REG_COUNT)
  ) u_regfile (
    .clk   (clk),
    .we    (ram_we),
    .waddr (addr),
    .wdata (ram_wdata),
    .re    (rd),
    .raddr (addr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chip_id_r   <= CHIP_ID_RESET;
      reg0_r      <= CHIP_ID_RESET;
      ptr_r       <= '0;
      pflag_r     <= 1'b1;
      nd_r        <= 3'b111;
      last_r      <= '0;
      vld_r       <= '0;
      range_r     <= REG_DEFAULTS[ADDR_RANGE];
      bw_r        <= REG_DEFAULTS[ADDR_BW];
      pwr_r       <= REG_DEFAULTS[ADDR_PWR];
      intout_r    <= REG_DEFAULTS[ADDR_INTOUT];
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        chip_id_r <= cfg_wdata;
      end
      reg0_r      <= reg0_nxt;
      ptr_r       <= ptr_nxt;
      pflag_r     <= pflag_nxt;
      nd_r        <= nd_nxt;
      last_r      <= last_nxt;
      vld_r       <= vld_nxt;
      range_r     <= range_nxt;
      bw_r        <= bw_nxt;
      pwr_r       <= pwr_nxt;
      intout_r    <= intout_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_ram_r  <= s1_ram_nxt;
      s1_byte_r <= s1_byte_nxt;
      s1_irq_r  <= ~intout_nxt[0];
    end
    if (s2_load) begin
      out_req_r.read_data <= s1_ram_r ? ram_rdata : s1_byte_r;
      out_req_r.irq_level <= s1_irq_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_req   = out_req_r;

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r))
    else $error("input stalled with a free stage");

  a_mid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s2_load) |=> s1_valid_r)
    else $error("middle stage lost a request");

  a_soft_nd: assert property (@(posedge clk) disable iff (!rst_n)
    soft_rst |=> (nd_r == 3'b111) && (last_r == $past(in_req.now_ns)))
    else $error("soft reset did not restart sampling");

  a_vld_range: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[14:0] == 15'd0) && !vld_r[ADDR_LAST] && !vld_r[ADDR_SOFTRST])
    else $error("valid bit set on a read-only register");

endmodule
